// File: design/kts_pkg.sv
// Shared types and constants for the Kahn topological sort engine.
package kts_pkg;

    // Fixed field widths of the transfer payloads and the edge record
    localparam int NODE_W  = 7;
    localparam int FIELD_W = 6;
    localparam int EDGE_W  = 2 * FIELD_W;

    // Item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Register index carried by paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              complete;
        logic              dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT,
        S_CNT_E,
        S_CNT_W,
        S_SEED,
        S_SEED_D,
        S_POP,
        S_POP_D,
        S_EMIT,
        S_SCAN,
        S_SCAN_E,
        S_SCAN_D,
        S_FIN
    } t_state;

endpackage

// File: design/kts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/kahn_topological_sort_top.sv
// Kahn topological sort engine: edge loading, sort sequencer and APB register.
//
// Edge items are taken one per cycle while the sequencer is idle and appended to the edge
// store; an edge with an endpoint of 0 or above node_count, or one that arrives with the store
// full, is dropped and sets the dropped flag. A run item holds o_in_ready low for the whole
// sort. The run clears the in-degree RAM for the nodes in use, recounts in-degrees from the
// stored edges, seeds the ready queue in ascending node order, then for each emitted node
// pops it from the queue and walks every stored edge through the single read port of the
// edge store to scan its out-edges. One result is given per emitted node; the final one
// carries last, and complete when every node in use was emitted, and a run that emits
// nothing gives a single result with node 0. A result waits in an output register while the
// sequencer moves on, so the next edge item is taken while the final result is still held.
// No clearing pass follows reset: in-degrees are rebuilt at the start of every run. Register
// node_count sits at byte address 0; writes of 0 give 1 and values above MAX_NODES saturate.
module kahn_topological_sort_top
    import kts_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NA_W  = $clog2(MAX_NODES);
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ET_W  = $clog2(MAX_EDGES + 1);
    localparam int DEG_W = $clog2(MAX_EDGES + 1);

    // Control registers
    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_node_count;
    logic [ET_W-1:0]     r_edge_total, n_edge_total;
    logic                r_drop, n_drop;
    logic [ET_W-1:0]     r_e, n_e;
    logic [NC_W-1:0]     r_i, n_i;
    logic [NC_W-1:0]     r_head, n_head;
    logic [NC_W-1:0]     r_tail, n_tail;
    logic [NC_W-1:0]     r_count, n_count;
    logic                r_pend_v, n_pend_v;
    logic                r_out_valid, n_out_valid;

    // Payload registers
    logic [NA_W-1:0]     r_x, n_x;
    logic [NA_W-1:0]     r_t, n_t;
    logic [NA_W-1:0]     r_pend, n_pend;
    t_out_item           r_out_item, n_out_item;

    // Memory ports
    logic                edge_we;
    logic [EA_W-1:0]     edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic                deg_we;
    logic [NA_W-1:0]     deg_waddr, deg_raddr;
    logic [DEG_W-1:0]    deg_wdata, deg_rdata;
    logic                q_we;
    logic [NA_W-1:0]     q_waddr, q_raddr;
    logic [NA_W-1:0]     q_wdata, q_rdata;

    logic                in_xfer;
    logic                cfg_write;
    logic                out_free;
    logic [FIELD_W-1:0]  edge_f, edge_t;
    logic                edge_in_range;
    logic                edge_bad;
    logic [NODE_W-1:0]   cfg_value;
    logic [NODE_W-1:0]   n_last_idx;

    kts_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    kts_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    kts_ram #(.WIDTH(NA_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // Handshakes and decoded edge record
    assign in_xfer       = i_in_valid && o_in_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out_item;
    assign out_free      = !r_out_valid || i_out_ready;
    assign edge_f        = edge_rdata[EDGE_W-1:FIELD_W];
    assign edge_t        = edge_rdata[FIELD_W-1:0];
    assign edge_in_range = ({1'b0, edge_t} < r_node_count);
    assign n_last_idx    = r_node_count - NODE_W'(1);

    // Reject edges out of range or past capacity
    assign edge_bad = (i_in_item.from_node == '0) || (i_in_item.from_node > r_node_count) ||
                      (i_in_item.to_node == '0)   || (i_in_item.to_node > r_node_count) ||
                      (r_edge_total == ET_W'(MAX_EDGES));

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ? {{(32-NODE_W){1'b0}}, r_node_count} : '0;

    always_comb begin
        if (pwdata[NODE_W-1:0] == '0) begin
            cfg_value = NODE_W'(1);
        end else if (pwdata[NODE_W-1:0] > NODE_W'(MAX_NODES)) begin
            cfg_value = NODE_W'(MAX_NODES);
        end else begin
            cfg_value = pwdata[NODE_W-1:0];
        end
    end

    // Sequencer: next state, counters, memory controls and result register
    always_comb begin
        n_state      = r_state;
        n_edge_total = r_edge_total;
        n_drop       = r_drop;
        n_e          = r_e;
        n_i          = r_i;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pend_v     = r_pend_v;
        n_x          = r_x;
        n_t          = r_t;
        n_pend       = r_pend;
        n_out_item   = r_out_item;
        n_out_valid  = r_out_valid && !i_out_ready;

        edge_we    = 1'b0;
        edge_waddr = r_edge_total[EA_W-1:0];
        edge_wdata = {FIELD_W'(i_in_item.from_node - NODE_W'(1)),
                      FIELD_W'(i_in_item.to_node - NODE_W'(1))};
        edge_raddr = r_e[EA_W-1:0];
        deg_we     = 1'b0;
        deg_waddr  = r_t;
        deg_wdata  = '0;
        deg_raddr  = edge_t[NA_W-1:0];
        q_we       = 1'b0;
        q_waddr    = r_tail[NA_W-1:0];
        q_wdata    = r_t;
        q_raddr    = r_head[NA_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_item.kind == KIND_RUN) begin
                        n_i      = '0;
                        n_head   = '0;
                        n_tail   = '0;
                        n_count  = '0;
                        n_pend_v = 1'b0;
                        n_state  = S_CLR;
                    end else if (edge_bad) begin
                        n_drop = 1'b1;
                    end else begin
                        edge_we      = 1'b1;
                        n_edge_total = r_edge_total + ET_W'(1);
                    end
                end
            end
            // Zero the in-degree of every node in use
            S_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = r_i[NA_W-1:0];
                deg_wdata = '0;
                n_i       = r_i + NC_W'(1);
                if (NODE_W'(r_i) == n_last_idx) begin
                    n_e     = '0;
                    n_state = S_CNT;
                end
            end
            // Recount in-degrees over stored edges inside the node range
            S_CNT: begin
                if (r_e == r_edge_total) begin
                    n_i     = '0;
                    n_state = S_SEED;
                end else begin
                    n_state = S_CNT_E;
                end
            end
            S_CNT_E: begin
                if (({1'b0, edge_f} < r_node_count) && edge_in_range) begin
                    n_t     = edge_t[NA_W-1:0];
                    n_state = S_CNT_W;
                end else begin
                    n_e     = r_e + ET_W'(1);
                    n_state = S_CNT;
                end
            end
            S_CNT_W: begin
                deg_we    = 1'b1;
                deg_wdata = deg_rdata + DEG_W'(1);
                n_e       = r_e + ET_W'(1);
                n_state   = S_CNT;
            end
            // Queue zero in-degree nodes in ascending order
            S_SEED: begin
                deg_raddr = r_i[NA_W-1:0];
                n_state   = S_SEED_D;
            end
            S_SEED_D: begin
                if (deg_rdata == '0) begin
                    q_we    = 1'b1;
                    q_wdata = r_i[NA_W-1:0];
                    n_tail  = r_tail + NC_W'(1);
                end
                n_i = r_i + NC_W'(1);
                if (NODE_W'(r_i) == n_last_idx) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_SEED;
                end
            end
            // Pop the next ready node
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    n_head  = r_head + NC_W'(1);
                    n_state = S_POP_D;
                end
            end
            S_POP_D: begin
                n_x     = q_rdata;
                n_state = S_EMIT;
            end
            // Release the held result and hold the popped node until its successor is known
            S_EMIT: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{node: NODE_W'(r_pend) + NODE_W'(1), last: 1'b0,
                                        complete: 1'b0, dropped: r_drop};
                    end
                    n_pend   = r_x;
                    n_pend_v = 1'b1;
                    n_count  = r_count + NC_W'(1);
                    n_e      = '0;
                    n_state  = S_SCAN;
                end
            end
            // Walk the out-edges of the popped node in load order
            S_SCAN: begin
                if (r_e == r_edge_total) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_SCAN_E;
                end
            end
            S_SCAN_E: begin
                if ((edge_f == FIELD_W'(r_x)) && edge_in_range) begin
                    n_t     = edge_t[NA_W-1:0];
                    n_state = S_SCAN_D;
                end else begin
                    n_e     = r_e + ET_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN_D: begin
                if (deg_rdata != '0) begin
                    deg_we    = 1'b1;
                    deg_wdata = deg_rdata - DEG_W'(1);
                    if (deg_rdata == DEG_W'(1)) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + NC_W'(1);
                    end
                end
                n_e     = r_e + ET_W'(1);
                n_state = S_SCAN;
            end
            // Give the final result and drop the stored graph
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_v) begin
                        n_out_item = '{node: NODE_W'(r_pend) + NODE_W'(1), last: 1'b1,
                                       complete: (NODE_W'(r_count) == r_node_count),
                                       dropped: r_drop};
                    end else begin
                        n_out_item = '{node: '0, last: 1'b1, complete: 1'b0,
                                       dropped: r_drop};
                    end
                    n_edge_total = '0;
                    n_drop       = 1'b0;
                    n_pend_v     = 1'b0;
                    n_count      = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(MAX_NODES);
            r_edge_total <= '0;
            r_drop       <= 1'b0;
            r_e          <= '0;
            r_i          <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pend_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_node_count <= cfg_value;
            end
            r_edge_total <= n_edge_total;
            r_drop       <= n_drop;
            r_e          <= n_e;
            r_i          <= n_i;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_pend_v     <= n_pend_v;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_t        <= n_t;
        r_pend     <= n_pend;
        r_out_item <= n_out_item;
    end

endmodule

// File: design/kts_checker.sv
// Port-level checks for the Kahn topological sort engine, bound to the top level.
module kts_checker
    import kts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or vanished while stalled");

    // Drop input ready once a run is taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.kind == KIND_RUN) |=> !o_in_ready)
        else $error("input still ready after a run transfer");

    // Flag complete only on the final result
    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.complete |-> o_out_item.last)
        else $error("complete set on a result that is not last");

    // Give node 0 only as the lone failed result
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.node == '0) |-> o_out_item.last && !o_out_item.complete)
        else $error("node 0 result without last or with complete");

endmodule

bind kahn_topological_sort_top kts_checker u_kts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// File: tb/kahn_topological_sort_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Kahn topological sort engine top level.
module kahn_topological_sort_top_test;
    import kts_pkg::*;

    localparam int MAX_NODES     = 64;
    localparam int MAX_EDGES     = 256;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 5;
    localparam int FILL_EDGES    = MAX_EDGES + 2;
    localparam int LIMIT_CYCLES  = 1_500_000;

    localparam logic [2:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = {~REG_NODE_COUNT, 2'b00};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: stored edges, drop flag and node count
    logic [FIELD_W-1:0] edge_src [MAX_EDGES];
    logic [FIELD_W-1:0] edge_dst [MAX_EDGES];
    int unsigned        edge_cnt  = 0;
    bit                 drop_seen = 1'b0;
    int unsigned        node_cnt  = MAX_NODES;

    t_out_item   exp_order [$];
    t_in_item    pending [$];
    int unsigned fault_cnt      = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          load_taken     = 1'b0;
    bit          recv_hold      = 1'b0;
    bit          hold_go        = 1'b0;

    kahn_topological_sort_top #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Store an edge, or run the sort and append the emitted order
    function automatic void predict_order(input t_in_item it);
        int unsigned n;
        int unsigned src;
        int unsigned dst;
        int unsigned x;
        int unsigned deg [MAX_NODES];
        int unsigned ready_nodes [$];
        t_out_item   run_out [$];
        t_out_item   r;
        n = node_cnt;
        if (it.kind == KIND_EDGE) begin
            src = it.from_node;
            dst = it.to_node;
            if (src < 1 || src > n || dst < 1 || dst > n || edge_cnt >= MAX_EDGES) begin
                drop_seen = 1'b1;
            end else begin
                edge_src[edge_cnt] = FIELD_W'(src - 1);
                edge_dst[edge_cnt] = FIELD_W'(dst - 1);
                edge_cnt++;
            end
        end else begin
            // recount in-degrees over edges that fit the current node count
            foreach (deg[i]) deg[i] = 0;
            for (int e = 0; e < edge_cnt; e++)
                if (edge_src[e] < n && edge_dst[e] < n) deg[edge_dst[e]]++;
            for (int i = 0; i < n; i++)
                if (deg[i] == 0) ready_nodes.insert(ready_nodes.size(), i);
            while (ready_nodes.size() > 0) begin
                x = ready_nodes.pop_front();
                r.node     = NODE_W'(x + 1);
                r.last     = 1'b0;
                r.complete = 1'b0;
                r.dropped  = drop_seen;
                run_out.insert(run_out.size(), r);
                for (int e = 0; e < edge_cnt; e++) begin
                    if (edge_src[e] == x && edge_dst[e] < n && deg[edge_dst[e]] > 0) begin
                        deg[edge_dst[e]]--;
                        if (deg[edge_dst[e]] == 0)
                            ready_nodes.insert(ready_nodes.size(), edge_dst[e]);
                    end
                end
            end
            if (run_out.size() == 0) begin
                r.node     = '0;
                r.last     = 1'b1;
                r.complete = 1'b0;
                r.dropped  = drop_seen;
                run_out.insert(run_out.size(), r);
            end else begin
                r          = run_out[run_out.size() - 1];
                r.last     = 1'b1;
                r.complete = (run_out.size() == n);
                run_out[run_out.size() - 1] = r;
            end
            foreach (run_out[k]) exp_order.insert(exp_order.size(), run_out[k]);
            edge_cnt  = 0;
            drop_seen = 1'b0;
        end
    endfunction

    // Compare one result with the oldest expectation
    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (exp_order.size() == 0) begin
            if (fault_cnt < MAX_REPORTS)
                $display("unexpected result: node %0d last %0b complete %0b dropped %0b",
                         got.node, got.last, got.complete, got.dropped);
            fault_cnt++;
        end else begin
            want = exp_order.pop_front();
            if (got.node !== want.node || got.last !== want.last ||
                got.complete !== want.complete || got.dropped !== want.dropped) begin
                if (fault_cnt < MAX_REPORTS)
                    $display({"result mismatch: expected node %0d last %0b complete %0b ",
                              "dropped %0b, got node %0d last %0b complete %0b dropped %0b"},
                             want.node, want.last, want.complete, want.dropped,
                             got.node, got.last, got.complete, got.dropped);
                fault_cnt++;
            end
        end
    endfunction

    // Offer the next pending item once the current one has been transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || load_taken) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random, or hold it off entirely
    always @(negedge i_clk) begin
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch both channels: predict on each item transfer, check each result transfer
    always @(posedge i_clk) begin
        load_taken = i_rst_n && i_in_valid && o_in_ready;
        if (load_taken) predict_order(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_item);
    end

    // Hold off the receiver for a long stretch once asked
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    // End the run if it hangs
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("kahn_topological_sort_top_test NOT OK");
        $finish;
    end

    function automatic void push_edge(input int unsigned src, input int unsigned dst);
        t_in_item it;
        it.kind      = KIND_EDGE;
        it.from_node = NODE_W'(src);
        it.to_node   = NODE_W'(dst);
        pending.insert(pending.size(), it);
    endfunction

    // Run item; the node fields carry random filler
    function automatic void push_run();
        t_in_item it;
        it.kind      = KIND_RUN;
        it.from_node = NODE_W'($urandom_range(0, 127));
        it.to_node   = NODE_W'($urandom_range(0, 127));
        pending.insert(pending.size(), it);
    endfunction

    // Mostly in-range edges, many of them forward so that runs often finish
    function automatic t_in_item random_edge();
        t_in_item    it;
        int unsigned src;
        it.kind = KIND_EDGE;
        if ($urandom_range(99) < 12) begin
            it.from_node = NODE_W'($urandom_range(0, 127));
            it.to_node   = NODE_W'($urandom_range(0, 127));
        end else if (node_cnt > 1 && $urandom_range(99) < 60) begin
            src          = $urandom_range(1, node_cnt - 1);
            it.from_node = NODE_W'(src);
            it.to_node   = NODE_W'($urandom_range(src + 1, node_cnt));
        end else begin
            it.from_node = NODE_W'($urandom_range(1, node_cnt));
            it.to_node   = NODE_W'($urandom_range(1, node_cnt));
        end
        return it;
    endfunction

    // Write one register through a setup and an access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == REG_NODE_COUNT) begin
            if (data[6:0] == 0) node_cnt = 1;
            else if (data[6:0] > MAX_NODES) node_cnt = MAX_NODES;
            else node_cnt = data[6:0];
        end
    endtask

    // Wait until every item is transferred and every result has come back
    task automatic wait_idle();
        while (pending.size() > 0 || i_in_valid || exp_order.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Set the node count and idling, then queue random edge runs
    task automatic random_phase(input logic [31:0] setting, input int unsigned send_pct,
                                input int unsigned recv_pct);
        int unsigned added;
        int unsigned k;
        wait_idle();
        write_reg(ADDR_NODE_COUNT, setting);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        added = 0;
        while (added < PHASE_ITEMS) begin
            k = $urandom_range(0, 4);
            repeat (k) pending.insert(pending.size(), random_edge());
            added += k;
            // leave an occasional batch without its run so edges carry over
            if ($urandom_range(9) != 0) begin
                push_run();
                added++;
            end
        end
    endtask

    initial begin
        int unsigned settings [4]  = '{33, 5, 127, 12};
        int unsigned send_mode [4] = '{0, 75, 0, 8};
        int unsigned recv_mode [4] = '{0, 0, 75, 8};
        int unsigned src;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at the reset node count: cycle through 1 and 64, bad endpoints
        push_edge(1, MAX_NODES);
        push_edge(MAX_NODES, 1);
        push_edge(MAX_NODES, MAX_NODES);
        push_edge(0, 5);
        push_edge(5, 127);
        push_edge(MAX_NODES + 1, 2);
        push_run();
        // short chain, then a run on an empty store
        push_edge(2, 3);
        push_edge(3, 4);
        push_edge(1, 2);
        push_run();
        push_run();

        // single node: self loop emits nothing, out-of-range edge is dropped
        wait_idle();
        write_reg(ADDR_NODE_COUNT, 32'd1);
        @(posedge i_clk);
        push_edge(1, 1);
        push_run();
        push_edge(1, 2);
        push_run();

        // zero node count rounds up; unmapped register is ignored
        wait_idle();
        write_reg(ADDR_NODE_COUNT, 32'd0);
        write_reg(ADDR_UNMAPPED, 32'd9);
        @(posedge i_clk);
        push_run();

        // load at the saturated maximum, shrink the node count, then run
        wait_idle();
        write_reg(ADDR_NODE_COUNT, 32'd200);
        @(posedge i_clk);
        push_edge(10, 3);
        push_edge(3, 12);
        push_edge(40, 50);
        push_edge(12, 1);
        wait_idle();
        write_reg(ADDR_NODE_COUNT, 32'd12);
        @(posedge i_clk);
        push_run();

        // overfill the edge store with forward edges
        wait_idle();
        write_reg(ADDR_NODE_COUNT, 32'd8);
        @(posedge i_clk);
        repeat (FILL_EDGES) begin
            src = $urandom_range(1, 7);
            push_edge(src, $urandom_range(src + 1, 8));
        end
        push_run();

        // one random phase per idling mode, receiver hold-off in the first
        for (int p = 0; p < 4; p++) begin
            random_phase(settings[p], send_mode[p], recv_mode[p]);
            if (p == 0) hold_go = 1'b1;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fault_cnt += exp_order.size();
        if (fault_cnt == 0) begin
            $display("kahn_topological_sort_top_test OK");
        end else begin
            $display("kahn_topological_sort_top_test NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/kts_pkg.sv
design/kts_ram.sv
design/kahn_topological_sort_top.sv
design/kts_checker.sv
tb/kahn_topological_sort_top_test.sv
